@@ hdl/gafc_pkg.sv @@
// Shared types and constants for the gated average frequency counter.
// No dependencies; imported by gated_average_frequency_counter.
package gafc_pkg;

    localparam int STAMP_W = 32;
    localparam int COUNT_W = 16;
    localparam int FREQ_W  = 48;
    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // Register reset values: 80 MHz timestamp clock, mains window of 40..70 Hz.
    localparam logic [STAMP_W-1:0] CLOCK_HZ_RST   = 32'd80000000;
    localparam logic [STAMP_W-1:0] PERIOD_MIN_RST = 32'd1142857;
    localparam logic [STAMP_W-1:0] PERIOD_MAX_RST = 32'd2000000;

    // Register index, taken from the word address of the configuration port.
    typedef enum logic [1:0] {
        REG_CLOCK_HZ   = 2'd0,
        REG_PERIOD_MIN = 2'd1,
        REG_PERIOD_MAX = 2'd2,
        REG_UNUSED     = 2'd3
    } reg_idx_t;

    localparam logic KIND_EDGE    = 1'b0;
    localparam logic KIND_READOUT = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_EDGE  = 6'b000010,
        ST_MUL   = 6'b000100,
        ST_DIV   = 6'b001000,
        ST_ROUND = 6'b010000,
        ST_DONE  = 6'b100000
    } state_t;

endpackage

@@ hdl/gated_average_frequency_counter.sv @@
// Top level of the gated average frequency counter: window check, period
// accumulation and an iterative restoring divider for the readout.
// Depends on gafc_pkg.
//
//  Channel | Direction | Handshake          | Payload
//  --------+-----------+--------------------+------------------------------------------
//  in      | sink      | in_valid/in_stall   | kind, timestamp
//  out     | source    | out_valid/out_stall | freq_q16, valid_res, period_count, noise_count
//  cfg     | APB slave | psel/penable/pready | paddr, pwrite, pwdata, prdata
//
// An edge transfer forms the period on acceptance, then does the window check and
// the saturating add in ST_EDGE. A readout goes through ST_MUL, the one-bit-per-cycle
// divider loop in ST_DIV, ST_ROUND and ST_DONE; an empty readout or one with a zero
// sum goes straight to ST_DONE. rst_n clears all counters and loads the register
// defaults at once. in_stall is high whenever the sequencer is busy, and a finished
// readout waits in ST_DONE while the output register is stalled.
module gated_average_frequency_counter #(
    parameter int FRAC_BITS = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // Input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic [gafc_pkg::STAMP_W-1:0]  timestamp,
    // Output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [gafc_pkg::FREQ_W-1:0]   freq_q16,
    output logic                          valid_res,
    output logic [gafc_pkg::COUNT_W-1:0]  period_count,
    output logic [gafc_pkg::STAMP_W-1:0]  noise_count,
    // Configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [gafc_pkg::ADDR_W-1:0]   paddr,
    input  logic [gafc_pkg::DATA_W-1:0]   pwdata,
    output logic [gafc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);
    import gafc_pkg::*;

    // The dividend is the 48-bit product shifted up by FRAC_BITS plus one
    // extra bit, so the last quotient bit is the rounding bit.
    localparam int QW    = FREQ_W + FRAC_BITS + 1;
    localparam int CNT_W = $clog2(QW);
    localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QW - 1);

    // Configuration registers.
    logic [STAMP_W-1:0] clock_hz_reg;
    logic [STAMP_W-1:0] period_min_reg;
    logic [STAMP_W-1:0] period_max_reg;

    // Measurement state.
    logic [STAMP_W-1:0] last_stamp_reg, last_stamp_next;
    logic [STAMP_W-1:0] period_sum_reg, period_sum_next;
    logic [COUNT_W-1:0] acc_count_reg, acc_count_next;
    logic [STAMP_W-1:0] rej_count_reg, rej_count_next;

    // Sequencer and divider datapath.
    state_t             state_reg, state_next;
    logic [STAMP_W-1:0] period_reg, period_next;
    logic [STAMP_W-1:0] den_reg, den_next;
    logic [COUNT_W-1:0] snap_count_reg, snap_count_next;
    logic [QW-1:0]      dvd_reg, dvd_next;
    logic [STAMP_W-1:0] rem_reg, rem_next;
    logic [CNT_W-1:0]   step_reg, step_next;
    logic [FREQ_W-1:0]  res_freq_reg, res_freq_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic [FREQ_W-1:0]  freq_reg, freq_next;
    logic               vres_reg, vres_next;
    logic [COUNT_W-1:0] pcount_reg, pcount_next;
    logic [STAMP_W-1:0] ncount_reg, ncount_next;

    logic               in_fire;
    logic               cfg_write;
    logic [STAMP_W:0]   sum_wide;
    logic               in_window;
    logic [FREQ_W-1:0]  product;
    logic [STAMP_W:0]   rem_shift;
    logic               rem_ge;
    logic [STAMP_W:0]   rem_diff;
    logic [QW-1:0]      rounded;
    logic               int_over;

    assign in_fire   = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_IDLE);
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    // Configuration port: three words, a write to the fourth is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clock_hz_reg   <= CLOCK_HZ_RST;
            period_min_reg <= PERIOD_MIN_RST;
            period_max_reg <= PERIOD_MAX_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[3:2]))
                REG_CLOCK_HZ:   clock_hz_reg   <= pwdata;
                REG_PERIOD_MIN: period_min_reg <= pwdata;
                REG_PERIOD_MAX: period_max_reg <= pwdata;
                REG_UNUSED:     ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx_t'(paddr[3:2]))
            REG_CLOCK_HZ:   prdata = clock_hz_reg;
            REG_PERIOD_MIN: prdata = period_min_reg;
            REG_PERIOD_MAX: prdata = period_max_reg;
            REG_UNUSED:     prdata = '0;
        endcase
    end

    // Window check and saturating accumulation of one period.
    assign in_window = (period_reg >= period_min_reg) && (period_reg <= period_max_reg);
    assign sum_wide  = {1'b0, period_sum_reg} + {1'b0, period_reg};

    // 32 x 16 product that forms the numerator clock_hz * count.
    assign product = clock_hz_reg * snap_count_reg;

    // One restoring division step: bring down the next dividend bit, and
    // subtract the denominator whenever the partial remainder reaches it.
    assign rem_shift = {rem_reg, dvd_reg[QW-1]};
    assign rem_diff  = rem_shift - {1'b0, den_reg};
    assign rem_ge    = (rem_shift >= {1'b0, den_reg});

    // The quotient carries one bit below the fraction; adding it rounds half up.
    assign rounded  = {1'b0, dvd_reg[QW-1:1]} + QW'(dvd_reg[0]);
    assign int_over = ((dvd_reg >> (FREQ_W + 1)) != '0);

    always_comb
    begin
        state_next      = state_reg;
        last_stamp_next = last_stamp_reg;
        period_sum_next = period_sum_reg;
        acc_count_next  = acc_count_reg;
        rej_count_next  = rej_count_reg;
        period_next     = period_reg;
        den_next        = den_reg;
        snap_count_next = snap_count_reg;
        dvd_next        = dvd_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        res_freq_next   = res_freq_reg;
        out_valid_next  = out_valid_reg && out_stall;
        freq_next       = freq_reg;
        vres_next       = vres_reg;
        pcount_next     = pcount_reg;
        ncount_next     = ncount_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (kind == KIND_EDGE)
                    begin
                        period_next     = timestamp - last_stamp_reg;
                        last_stamp_next = timestamp;
                        state_next      = ST_EDGE;
                    end
                    else
                    begin
                        // Take a snapshot and clear the accumulators at once.
                        snap_count_next = acc_count_reg;
                        den_next        = period_sum_reg;
                        period_sum_next = '0;
                        acc_count_next  = '0;
                        if (acc_count_reg == '0)
                        begin
                            res_freq_next = '0;
                            state_next    = ST_DONE;
                        end
                        else if (period_sum_reg == '0)
                        begin
                            res_freq_next = '1;
                            state_next    = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_MUL;
                        end
                    end
                end
            end
            ST_EDGE:
            begin
                if (in_window)
                begin
                    period_sum_next = sum_wide[STAMP_W] ? '1 : sum_wide[STAMP_W-1:0];
                    if (acc_count_reg != '1)
                    begin
                        acc_count_next = acc_count_reg + 1'b1;
                    end
                end
                else
                begin
                    rej_count_next = rej_count_reg + 1'b1;
                end
                state_next = ST_IDLE;
            end
            ST_MUL:
            begin
                dvd_next   = {product, {(FRAC_BITS + 1){1'b0}}};
                rem_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = rem_ge ? rem_diff[STAMP_W-1:0] : rem_shift[STAMP_W-1:0];
                dvd_next  = {dvd_reg[QW-2:0], rem_ge};
                step_next = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                if (int_over || ((rounded >> FREQ_W) != '0))
                begin
                    res_freq_next = '1;
                end
                else
                begin
                    res_freq_next = rounded[FREQ_W-1:0];
                end
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    freq_next      = res_freq_reg;
                    vres_next      = (snap_count_reg != '0);
                    pcount_next    = snap_count_reg;
                    ncount_next    = rej_count_reg;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            last_stamp_reg <= '0;
            period_sum_reg <= '0;
            acc_count_reg  <= '0;
            rej_count_reg  <= '0;
            out_valid_reg  <= 1'b0;
            step_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            last_stamp_reg <= last_stamp_next;
            period_sum_reg <= period_sum_next;
            acc_count_reg  <= acc_count_next;
            rej_count_reg  <= rej_count_next;
            out_valid_reg  <= out_valid_next;
            step_reg       <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        period_reg     <= period_next;
        den_reg        <= den_next;
        snap_count_reg <= snap_count_next;
        dvd_reg        <= dvd_next;
        rem_reg        <= rem_next;
        res_freq_reg   <= res_freq_next;
        freq_reg       <= freq_next;
        vres_reg       <= vres_next;
        pcount_reg     <= pcount_next;
        ncount_reg     <= ncount_next;
    end

    assign out_valid    = out_valid_reg;
    assign freq_q16     = freq_reg;
    assign valid_res    = vres_reg;
    assign period_count = pcount_reg;
    assign noise_count  = ncount_reg;

    // A new result only appears when the sequencer hands it over.
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_DONE))
        else $error("result appeared outside the hand-over state");

    // An empty accumulator always has a zero sum.
    a_empty_sum_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_count_reg == '0) |-> (period_sum_reg == '0))
        else $error("period sum nonzero with no accepted period");

    // The divider never runs past its last step.
    a_div_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (step_reg <= LAST_STEP))
        else $error("divider step counter overran");

    // An invalid result reports zero frequency and zero periods.
    a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !valid_res) |-> (freq_q16 == '0 && period_count == '0))
        else $error("empty readout carries nonzero data");

    // Edges are only taken in while idle, so the period sum never changes
    // during a division.
    a_sum_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |=> $stable(period_sum_reg))
        else $error("period sum changed during a division");

endmodule

@@ sim/tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for gated_average_frequency_counter: a queue-fed driver,
// a clocked monitor, an APB register writer and an in-order readout predictor.
// Depends on gafc_pkg and the gated_average_frequency_counter RTL.
module tb;
    import gafc_pkg::*;

    localparam int          FRAC_BITS    = 16;
    // Drain margin that covers a full readout through the divider.
    localparam int          DRAIN_CYCLES = 90;
    localparam int unsigned CYCLE_LIMIT  = 2000000;

    // One input transfer: an edge capture or a readout request.
    typedef struct {
        logic               kind;
        logic [STAMP_W-1:0] stamp;
    } capture_t;

    // One expected readout, field for field as the block reports it.
    typedef struct {
        logic [FREQ_W-1:0]  freq;
        logic               ok;
        logic [COUNT_W-1:0] count;
        logic [STAMP_W-1:0] noise;
    } readout_t;

    logic               clk;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               kind         = KIND_EDGE;
    logic [STAMP_W-1:0] timestamp    = '0;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic [FREQ_W-1:0]  freq_q16;
    logic               valid_res;
    logic [COUNT_W-1:0] period_count;
    logic [STAMP_W-1:0] noise_count;
    logic               psel         = 1'b0;
    logic               penable      = 1'b0;
    logic               pwrite       = 1'b0;
    logic [ADDR_W-1:0]  paddr        = '0;
    logic [DATA_W-1:0]  pwdata       = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    gated_average_frequency_counter #(.FRAC_BITS(FRAC_BITS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .timestamp    (timestamp),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .freq_q16     (freq_q16),
        .valid_res    (valid_res),
        .period_count (period_count),
        .noise_count  (noise_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    // Transfers waiting to be driven, and readouts the block still owes us.
    capture_t captures_pending[$];
    readout_t readouts_due[$];
    capture_t next_capture;

    // Shadow of the block's registers and counters, kept in step with every
    // accepted transfer and every completed register write.
    logic [STAMP_W-1:0] clock_hz    = CLOCK_HZ_RST;
    logic [STAMP_W-1:0] period_min  = PERIOD_MIN_RST;
    logic [STAMP_W-1:0] period_max  = PERIOD_MAX_RST;
    logic [STAMP_W-1:0] last_stamp  = '0;
    logic [STAMP_W-1:0] period_sum  = '0;
    logic [COUNT_W-1:0] accepted    = '0;
    logic [STAMP_W-1:0] noise_total = '0;

    // Stimulus-side timestamp of the last queued edge; last_stamp catches up to it.
    logic [STAMP_W-1:0] gen_stamp   = '0;

    int unsigned idle_pct  = 0;
    int unsigned stall_pct = 0;
    logic        in_took   = 1'b0;

    int unsigned cycles         = 0;
    int unsigned mismatches     = 0;
    int unsigned edges_seen     = 0;
    int unsigned readouts_seen  = 0;
    int unsigned valid_seen     = 0;
    int unsigned saturated_seen = 0;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Rounded-to-nearest mean frequency hz * n / sum with FRAC_BITS fraction bits.
    // Adding half the divisor before the division gives the half-up rounding, and
    // the wide intermediate lets the saturation test be done on the final value.
    function automatic logic [FREQ_W-1:0] mean_frequency(input logic [STAMP_W-1:0] hz,
                                                         input logic [COUNT_W-1:0] n,
                                                         input logic [STAMP_W-1:0] sum);
        logic [95:0] num;
        logic [95:0] den;
        logic [95:0] quo;
        num = hz;
        num = num * n;
        den = sum;
        num = (num << (FRAC_BITS + 1)) + den;
        quo = num / (den << 1);
        if (quo > 96'hFFFF_FFFF_FFFF)
            return '1;
        return quo[FREQ_W-1:0];
    endfunction

    // Advance the shadow state by one accepted transfer; a readout request
    // also queues the result that the block must produce for it.
    task automatic account_transfer(input logic k, input logic [STAMP_W-1:0] stamp);
        logic [STAMP_W-1:0] period;
        logic [STAMP_W:0]   wide_sum;
        readout_t           r;
        if (k == KIND_EDGE) begin
            period     = stamp - last_stamp;
            last_stamp = stamp;
            edges_seen++;
            if (period < period_min || period > period_max) begin
                noise_total = noise_total + 1'b1;
            end
            else begin
                wide_sum   = {1'b0, period_sum} + {1'b0, period};
                period_sum = wide_sum[STAMP_W] ? '1 : wide_sum[STAMP_W-1:0];
                if (accepted != '1)
                    accepted = accepted + 1'b1;
            end
        end
        else begin
            r.freq  = '0;
            r.ok    = (accepted != 0);
            r.count = accepted;
            r.noise = noise_total;
            if (accepted != 0)
                r.freq = (period_sum == 0) ? '1 : mean_frequency(clock_hz, accepted, period_sum);
            readouts_due.push_back(r);
            period_sum = '0;
            accepted   = '0;
        end
    endtask

    task automatic flag_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
        mismatches++;
        if (mismatches <= 10)
            $display("readout %0d: %s expected %0h, got %0h", readouts_seen, what, want, got);
    endtask

    // Compare the result transfer on the output channel with the oldest expectation.
    task automatic check_readout();
        readout_t r;
        if (readouts_due.size() == 0) begin
            flag_mismatch("unexpected result, freq_q16", 64'd0, {16'd0, freq_q16});
        end
        else begin
            r = readouts_due.pop_front();
            if (freq_q16 !== r.freq)
                flag_mismatch("freq_q16", {16'd0, r.freq}, {16'd0, freq_q16});
            if (valid_res !== r.ok)
                flag_mismatch("valid_res", {63'd0, r.ok}, {63'd0, valid_res});
            if (period_count !== r.count)
                flag_mismatch("period_count", {48'd0, r.count}, {48'd0, period_count});
            if (noise_count !== r.noise)
                flag_mismatch("noise_count", {32'd0, r.noise}, {32'd0, noise_count});
            if (r.ok)
                valid_seen++;
            if (r.freq == '1)
                saturated_seen++;
        end
        readouts_seen++;
    endtask

    // Monitor: everything is sampled at the rising edge, where inputs are stable
    // because the driver only moves them on the falling edge.
    always @(posedge clk)
    begin
        if (rst_n) begin
            in_took = in_valid && !in_stall;
            if (out_valid && !out_stall)
                check_readout();
            if (in_took)
                account_transfer(kind, timestamp);
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_CLOCK_HZ:   clock_hz   = pwdata;
                    REG_PERIOD_MIN: period_min = pwdata;
                    REG_PERIOD_MAX: period_max = pwdata;
                    default:        ;
                endcase
            end
        end
    end

    // Driver: a new transfer is presented only once the previous one has been
    // taken, so a stalled payload holds still. Valid is decided without looking
    // at in_stall; the receiver stall is an independent coin toss each cycle.
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_took)) begin
            if (captures_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
                next_capture = captures_pending.pop_front();
                in_valid  <= 1'b1;
                kind      <= next_capture.kind;
                timestamp <= next_capture.stamp;
            end
            else begin
                in_valid <= 1'b0;
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("gated_average_frequency_counter regression: fail");
            $finish;
        end
    end

    task automatic push_stamp(input logic [STAMP_W-1:0] stamp);
        capture_t c;
        c.kind    = KIND_EDGE;
        c.stamp   = stamp;
        gen_stamp = stamp;
        captures_pending.push_back(c);
    endtask

    task automatic push_edge(input logic [STAMP_W-1:0] period);
        push_stamp(gen_stamp + period);
    endtask

    // The timestamp of a readout is ignored by the block, so it carries noise.
    task automatic push_readout();
        capture_t c;
        c.kind  = KIND_READOUT;
        c.stamp = $urandom;
        captures_pending.push_back(c);
    endtask

    // Mostly periods inside the window, with the rest below it, above it or anywhere.
    function automatic logic [STAMP_W-1:0] pick_period();
        int unsigned roll;
        roll = $urandom_range(99);
        if (roll < 70 && period_min <= period_max)
            return $urandom_range(period_max, period_min);
        if (roll < 85 && period_min != 0)
            return $urandom_range(period_min - 1, 0);
        if (roll < 95 && period_max != '1)
            return $urandom_range(32'hFFFF_FFFF, period_max + 1);
        return $urandom;
    endfunction

    // Hold the sender back until every owed readout has arrived, then give the
    // block time to finish any edge work that produces no result.
    task automatic wait_idle();
        while (captures_pending.size() != 0 || in_valid || readouts_due.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle until pready.
    task automatic write_reg(input reg_idx_t idx, input logic [DATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_window(input logic [STAMP_W-1:0] hz, input logic [STAMP_W-1:0] lo,
                              input logic [STAMP_W-1:0] hi);
        write_reg(REG_CLOCK_HZ, hz);
        write_reg(REG_PERIOD_MIN, lo);
        write_reg(REG_PERIOD_MAX, hi);
    endtask

    // A random phase of mains-like traffic: edges with readouts mixed in, and
    // always a closing readout so the accumulated periods get checked.
    task automatic random_traffic(input int unsigned n);
        for (int unsigned i = 0; i < n; i++) begin
            if ($urandom_range(11) == 0)
                push_readout();
            else
                push_edge(pick_period());
        end
        push_readout();
    endtask

    initial
    begin
        logic [STAMP_W-1:0] hz;
        logic [STAMP_W-1:0] lo;
        // Single reset at the start of the run.
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset register values (80 MHz, 40..70 Hz window).
        // A readout before any edge is empty and must report valid_res low.
        push_readout();
        // The first edge is measured from a timestamp of zero.
        push_edge(32'd1200000);
        // Window boundaries: both limits are inclusive.
        push_edge(PERIOD_MIN_RST);
        push_edge(PERIOD_MAX_RST);
        push_edge(PERIOD_MIN_RST - 1);
        push_edge(PERIOD_MAX_RST + 1);
        push_readout();
        // The timestamp wraps past zero; the period is taken modulo 2^32.
        push_stamp(32'hFFFF_FFF0);
        push_edge(32'd1500000);
        push_readout();
        // All-zero and all-one timestamps.
        push_stamp(32'h0000_0000);
        push_stamp(32'hFFFF_FFFF);
        push_readout();
        wait_idle();

        // Zero-width window at zero: only repeated timestamps are accepted, so the
        // sum stays zero and the frequency saturates.
        set_window(32'hFFFF_FFFF, 32'd0, 32'd0);
        push_edge(32'd0);
        push_edge(32'd0);
        push_edge(32'd1);
        push_readout();
        wait_idle();

        // Widest window: huge periods make the sum saturate; a tiny sum against
        // the largest clock rate pushes the quotient past 48 bits.
        set_window(32'd1, 32'd0, 32'hFFFF_FFFF);
        push_edge(32'hC000_0000);
        push_edge(32'hC000_0000);
        push_readout();
        wait_idle();
        write_reg(REG_CLOCK_HZ, 32'hFFFF_FFFF);
        push_edge(32'd0);
        push_edge(32'd1);
        push_readout();
        wait_idle();

        // Inverted window: every period is noise and the readout is empty.
        set_window(PERIOD_MIN_RST, 32'd5, 32'd4);
        push_edge(32'd4);
        push_edge(32'd5);
        push_readout();
        wait_idle();

        // Random phases sweep the idle modes against several register settings.
        for (int p = 0; p < 8; p++) begin
            case (p % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 75; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 75; end
                default: begin idle_pct = 35; stall_pct = 35; end
            endcase
            case ((p + p / 4) % 4)
                0: set_window(CLOCK_HZ_RST, PERIOD_MIN_RST, PERIOD_MAX_RST);
                1: begin
                    // A mains window scaled to a random timestamp clock.
                    hz = $urandom_range(200000000, 1000000);
                    set_window(hz, hz / 70, hz / 40);
                end
                2: begin
                    lo = $urandom_range(32'h0010_0000, 0);
                    set_window($urandom | 32'd1, lo, lo + $urandom_range(32'h0010_0000, 0));
                end
                default: set_window(32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
            endcase
            random_traffic(164);
            wait_idle();
        end

        $display("covered %0d edge transfers and %0d readouts, %0d with a valid mean",
                 edges_seen, readouts_seen, valid_seen);
        $display("%0d saturated readouts; register sweep included both window extremes",
                 saturated_seen);
        if (mismatches == 0 && readouts_due.size() == 0) begin
            $display("gated_average_frequency_counter regression: pass");
        end
        else begin
            $display("%0d mismatches, %0d readouts outstanding", mismatches,
                     readouts_due.size());
            $display("gated_average_frequency_counter regression: fail");
        end
        $finish;
    end

endmodule
